### rtl/fldt_pkg.sv
`timescale 1ns / 1ps

package fldt_pkg;

  localparam int unsigned DEF_HISTORY_DEPTH = 10;
  localparam int unsigned DEF_WARMUP_FRAMES = 5;

  localparam int unsigned CRD_W  = 20;
  localparam int unsigned RAT_W  = 16;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned ROOT_W = 21;
  localparam int unsigned SQ_W   = 2 * ROOT_W;
  localparam int unsigned REM_W  = 23;
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = NUM_W;

  localparam logic [CFG_IW-1:0] REG_EYE_THR   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_YAWN_THR  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BLINK_MIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BLINK_MAX = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LVL_ONE   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_LVL_TWO   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_BIAS      = 3'd6;

  localparam logic [15:0]      RST_EYE_THR   = 16'd1843;
  localparam logic [15:0]      RST_YAWN_THR  = 16'd3072;
  localparam logic [15:0]      RST_BLINK_MIN = 16'd2;
  localparam logic [15:0]      RST_BLINK_MAX = 16'd15;
  localparam logic [15:0]      RST_LVL_ONE   = 16'd15;
  localparam logic [15:0]      RST_LVL_TWO   = 16'd30;
  localparam logic [CRD_W-1:0] RST_BIAS      = 20'd26;

  localparam logic [1:0] LVL_ALERT  = 2'd0;
  localparam logic [1:0] LVL_DROWSY = 2'd1;
  localparam logic [1:0] LVL_VERY   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_DLD,
    ST_RDIV,
    ST_RING,
    ST_AVE,
    ST_AVM,
    ST_TRK
  } state_e;

endpackage

### rtl/face_landmark_drowsiness_tracker.sv
`timescale 1ns / 1ps
// channel  | handshake                | payload
// in       | in_valid_i / in_ready_o  | ten landmark coordinates, Q12.8
// out      | out_valid_o / out_ready_i| averages, level, blink and yawn totals
// cfg      | cfg_we_i                 | cfg_idx_i, cfg_data_i
// One request runs from acceptance to its registered result through six
// distances (each two squares on the shared multiplier and 21 root steps),
// two ratio divides and two averaging divides at 34 steps each on the shared
// divider, and control states. No new request while one is in work.
// Reset clears control state and totals; ring entries beyond the fill count are not cleared and go unused.
// A stalled result holds the output register and the finish of the next request.

module face_landmark_drowsiness_tracker import fldt_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int unsigned WARMUP_FRAMES = DEF_WARMUP_FRAMES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CRD_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CRD_W-1:0]  left_eye_x_i,
  input  logic [CRD_W-1:0]  left_eye_y_i,
  input  logic [CRD_W-1:0]  right_eye_x_i,
  input  logic [CRD_W-1:0]  right_eye_y_i,
  input  logic [CRD_W-1:0]  nose_x_i,
  input  logic [CRD_W-1:0]  nose_y_i,
  input  logic [CRD_W-1:0]  mouth_left_x_i,
  input  logic [CRD_W-1:0]  mouth_left_y_i,
  input  logic [CRD_W-1:0]  mouth_right_x_i,
  input  logic [CRD_W-1:0]  mouth_right_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RAT_W-1:0]  avg_eye_ratio_o,
  output logic [RAT_W-1:0]  avg_mouth_ratio_o,
  output logic [1:0]        drowsiness_level_o,
  output logic [15:0]       blink_total_o,
  output logic [15:0]       yawn_total_o
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = RAT_W + FW;

  state_e state_q, state_d;

  logic [15:0]      eye_thr_q, yawn_thr_q, bmin_q, bmax_q, lvl1_q, lvl2_q;
  logic [CRD_W-1:0] bias_q;

  logic [CRD_W-1:0] crd_q [10];
  logic [5:0]       cnt_q, cnt_d;
  logic [1:0]       didx_q, didx_d;
  logic             pair_q, pair_d;
  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [REM_W-1:0] den_q, den_d;
  logic [ROOT_W-1:0] dist_q [3];
  logic [ROOT_W-1:0] dist_d [3];
  logic [RAT_W-1:0] eye_r_q, eye_r_d, mouth_r_q, mouth_r_d;
  logic [RAT_W-1:0] avg_eye_q, avg_eye_d;

  logic [AW-1:0]    slot_q, slot_d;
  logic [FW-1:0]    frames_q, frames_d;
  logic [SW-1:0]    eye_sum_q, eye_sum_d, mouth_sum_q, mouth_sum_d;
  logic             flag_q, flag_d;
  logic [15:0]      run_q, run_d, blink_q, blink_d, yawn_q, yawn_d;

  logic             out_valid_q, out_valid_d;
  logic [RAT_W-1:0] o_eye_q, o_eye_d, o_mouth_q, o_mouth_d;
  logic [1:0]       o_lvl_q, o_lvl_d;

  logic [RAT_W-1:0] eye_ring [HISTORY_DEPTH];
  logic [RAT_W-1:0] mouth_ring [HISTORY_DEPTH];
  logic [RAT_W-1:0] eye_old_q, mouth_old_q;

  logic [CRD_W-1:0] pa_x, pa_y, pb_x, pb_y, dx, dy, mop;
  logic [2*CRD_W-1:0] prod;
  logic [ROOT_W+3:0] sq_t, sq_trial;
  logic [REM_W:0]    dv_t;
  logic              dv_ge;
  logic [NUM_W-1:0]  q_next;
  logic              full, warm, closed, accept, out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign full     = (frames_q == FW'(HISTORY_DEPTH));
  assign warm     = (7'(frames_q) >= 7'(WARMUP_FRAMES));

  // point pair for the current distance
  always_comb begin
    unique case ({pair_q, didx_q})
      3'b000:  begin pa_x = crd_q[4]; pa_y = crd_q[5]; pb_x = crd_q[0]; pb_y = crd_q[1]; end
      3'b001:  begin pa_x = crd_q[4]; pa_y = crd_q[5]; pb_x = crd_q[2]; pb_y = crd_q[3]; end
      3'b010:  begin pa_x = crd_q[0]; pa_y = crd_q[1]; pb_x = crd_q[2]; pb_y = crd_q[3]; end
      3'b100:  begin pa_x = crd_q[4]; pa_y = crd_q[5]; pb_x = crd_q[6]; pb_y = crd_q[7]; end
      3'b101:  begin pa_x = crd_q[4]; pa_y = crd_q[5]; pb_x = crd_q[8]; pb_y = crd_q[9]; end
      default: begin pa_x = crd_q[6]; pa_y = crd_q[7]; pb_x = crd_q[8]; pb_y = crd_q[9]; end
    endcase
  end

  assign dx   = (pa_x > pb_x) ? pa_x - pb_x : pb_x - pa_x;
  assign dy   = (pa_y > pb_y) ? pa_y - pb_y : pb_y - pa_y;
  assign mop  = (state_q == ST_SQX) ? dx : dy;
  assign prod = mop * mop;

  assign sq_t     = {rem_q, sq_q[SQ_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  assign dv_t   = {rem_q, num_q[NUM_W-1]};
  assign dv_ge  = (dv_t >= {1'b0, den_q});
  assign q_next = {num_q[NUM_W-2:0], dv_ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQRT;
      ST_SQRT: if (cnt_q == 6'(SQRT_STEPS - 1)) state_d = (didx_q == 2'd2) ? ST_DLD : ST_SQX;
      ST_DLD:  state_d = ST_RDIV;
      ST_RDIV: if (cnt_q == 6'(DIV_STEPS - 1)) state_d = pair_q ? ST_RING : ST_SQX;
      ST_RING: state_d = ST_AVE;
      ST_AVE:  if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_AVM;
      ST_AVM:  if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_TRK;
      ST_TRK:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; didx_d = didx_q; pair_d = pair_q;
    sq_d = sq_q; rem_d = rem_q; root_d = root_q; num_d = num_q; den_d = den_q;
    dist_d = dist_q; eye_r_d = eye_r_q; mouth_r_d = mouth_r_q; avg_eye_d = avg_eye_q;
    slot_d = slot_q; frames_d = frames_q; eye_sum_d = eye_sum_q; mouth_sum_d = mouth_sum_q;
    flag_d = flag_q; run_d = run_q; blink_d = blink_q; yawn_d = yawn_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_eye_d = o_eye_q; o_mouth_d = o_mouth_q; o_lvl_d = o_lvl_q;
    closed = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        didx_d = 2'd0;
        pair_d = 1'b0;
      end
      ST_SQX: sq_d = SQ_W'(prod);
      ST_SQY: begin
        sq_d   = sq_q + SQ_W'(prod);
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
      end
      ST_SQRT: begin
        if (sq_t >= sq_trial) begin
          rem_d  = REM_W'(sq_t - sq_trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(sq_t);
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        sq_d  = {sq_q[SQ_W-3:0], 2'b00};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SQRT_STEPS - 1)) begin
          dist_d[didx_q] = root_d;
          didx_d = (didx_q == 2'd2) ? 2'd0 : didx_q + 2'd1;
        end
      end
      ST_DLD: begin
        num_d = {(22'(dist_q[0]) + 22'(dist_q[1])), 12'b0};
        den_d = {(22'(dist_q[2]) + 22'(bias_q)), 1'b0};
        rem_d = '0;
        cnt_d = '0;
      end
      ST_RDIV, ST_AVE, ST_AVM: begin
        rem_d = dv_ge ? REM_W'(dv_t - {1'b0, den_q}) : REM_W'(dv_t);
        num_d = q_next;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == ST_RDIV) begin
            if (pair_q) mouth_r_d = (|q_next[NUM_W-1:RAT_W]) ? '1 : q_next[RAT_W-1:0];
            else        eye_r_d   = (|q_next[NUM_W-1:RAT_W]) ? '1 : q_next[RAT_W-1:0];
            pair_d = 1'b1;
          end else if (state_q == ST_AVE) begin
            avg_eye_d = q_next[RAT_W-1:0];
            num_d = NUM_W'(mouth_sum_q);
          end
        end
      end
      ST_RING: begin
        eye_sum_d   = eye_sum_q - (full ? SW'(eye_old_q) : '0) + SW'(eye_r_q);
        mouth_sum_d = mouth_sum_q - (full ? SW'(mouth_old_q) : '0) + SW'(mouth_r_q);
        slot_d   = (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + AW'(1);
        frames_d = full ? frames_q : frames_q + FW'(1);
        num_d = NUM_W'(eye_sum_d);
        den_d = REM_W'(frames_d);
        rem_d = '0;
        cnt_d = '0;
      end
      ST_TRK: begin
        if (out_free) begin
          o_eye_d   = avg_eye_q;
          o_mouth_d = num_q[RAT_W-1:0];
          o_lvl_d   = LVL_ALERT;
          out_valid_d = 1'b1;
          if (warm) begin
            closed = (avg_eye_q < eye_thr_q);
            if (closed) begin
              if (!flag_q) begin
                flag_d = 1'b1;
                run_d  = 16'd1;
              end else if (run_q != '1) begin
                run_d = run_q + 16'd1;
              end
            end else if (flag_q) begin
              if (run_q > bmin_q && run_q < bmax_q && blink_q != '1)
                blink_d = blink_q + 16'd1;
              flag_d = 1'b0;
              run_d  = '0;
            end
            if (num_q[RAT_W-1:0] > yawn_thr_q && yawn_q != '1) yawn_d = yawn_q + 16'd1;
            if (run_d > lvl2_q)      o_lvl_d = LVL_VERY;
            else if (run_d > lvl1_q) o_lvl_d = LVL_DROWSY;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      frames_q    <= '0;
      eye_sum_q   <= '0;
      mouth_sum_q <= '0;
      flag_q      <= 1'b0;
      run_q       <= '0;
      blink_q     <= '0;
      yawn_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      didx_q      <= '0;
      pair_q      <= 1'b0;
      eye_thr_q   <= RST_EYE_THR;
      yawn_thr_q  <= RST_YAWN_THR;
      bmin_q      <= RST_BLINK_MIN;
      bmax_q      <= RST_BLINK_MAX;
      lvl1_q      <= RST_LVL_ONE;
      lvl2_q      <= RST_LVL_TWO;
      bias_q      <= RST_BIAS;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      frames_q    <= frames_d;
      eye_sum_q   <= eye_sum_d;
      mouth_sum_q <= mouth_sum_d;
      flag_q      <= flag_d;
      run_q       <= run_d;
      blink_q     <= blink_d;
      yawn_q      <= yawn_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      didx_q      <= didx_d;
      pair_q      <= pair_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_EYE_THR:   eye_thr_q  <= cfg_data_i[15:0];
          REG_YAWN_THR:  yawn_thr_q <= cfg_data_i[15:0];
          REG_BLINK_MIN: bmin_q     <= cfg_data_i[15:0];
          REG_BLINK_MAX: bmax_q     <= cfg_data_i[15:0];
          REG_LVL_ONE:   lvl1_q     <= cfg_data_i[15:0];
          REG_LVL_TWO:   lvl2_q     <= cfg_data_i[15:0];
          REG_BIAS:      bias_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      crd_q[0] <= left_eye_x_i;   crd_q[1] <= left_eye_y_i;
      crd_q[2] <= right_eye_x_i;  crd_q[3] <= right_eye_y_i;
      crd_q[4] <= nose_x_i;       crd_q[5] <= nose_y_i;
      crd_q[6] <= mouth_left_x_i; crd_q[7] <= mouth_left_y_i;
      crd_q[8] <= mouth_right_x_i; crd_q[9] <= mouth_right_y_i;
    end
    sq_q      <= sq_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    num_q     <= num_d;
    den_q     <= den_d;
    dist_q    <= dist_d;
    eye_r_q   <= eye_r_d;
    mouth_r_q <= mouth_r_d;
    avg_eye_q <= avg_eye_d;
    o_eye_q   <= o_eye_d;
    o_mouth_q <= o_mouth_d;
    o_lvl_q   <= o_lvl_d;
  end

  // ratio history, entries beyond the fill count are never used
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RING) begin
      eye_ring[slot_q]   <= eye_r_q;
      mouth_ring[slot_q] <= mouth_r_q;
    end
    eye_old_q   <= eye_ring[slot_q];
    mouth_old_q <= mouth_ring[slot_q];
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign avg_eye_ratio_o    = o_eye_q;
  assign avg_mouth_ratio_o  = o_mouth_q;
  assign drowsiness_level_o = o_lvl_q;
  assign blink_total_o      = blink_q;
  assign yawn_total_o       = yawn_q;

endmodule

### rtl/fldt_checker.sv
`timescale 1ns / 1ps

module fldt_checker import fldt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  drowsiness_level_o,
  input logic [15:0] blink_total_o
);

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  ap_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  ap_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drowsiness_level_o != 2'd3)
    else $error("bad level");

  ap_blink_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_valid_o |=> blink_total_o >= $past(blink_total_o))
    else $error("blink total fell");

endmodule

bind face_landmark_drowsiness_tracker fldt_checker u_fldt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .drowsiness_level_o (drowsiness_level_o),
  .blink_total_o      (blink_total_o)
);
